// ===== sv/mads_pkg.sv =====
// ----------------------------------------------------------------------------
// Multi-axis DDA step generator package
// Shared sizes, constants, field types and pipeline structs of the step
// generator.
// ----------------------------------------------------------------------------
`default_nettype none

package mads_pkg;

   localparam int     AXIS_COUNT    = 6;
   localparam longint PHASE_SCALE   = 65536;
   localparam int     SEGMENT_TICKS = 4000;

   // Step count fields carried in one load beat, and the width of the masks.
   localparam int STEP_FIELDS = 6;
   localparam int STEP_W      = 16;
   localparam int MASK_W      = 6;
   localparam int LOAD_FIELDS = (AXIS_COUNT < STEP_FIELDS) ? AXIS_COUNT : STEP_FIELDS;

   localparam int AXIS_W = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
   localparam int MAG_W  = $clog2(SEGMENT_TICKS + 1);
   localparam int ACC_W  = $clog2(PHASE_SCALE);
   localparam int RATE_W = $clog2(PHASE_SCALE + 1);
   localparam int SUM_W  = $clog2(2 * PHASE_SCALE);

   // Rate = ceil(mag * PHASE_SCALE / SEGMENT_TICKS). The reciprocal estimate
   // is at most one below the floor, which the remainder check corrects.
   localparam int     RECIP_SHIFT = MAG_W;
   localparam longint RECIP       = (PHASE_SCALE << RECIP_SHIFT) / SEGMENT_TICKS;
   localparam int     RECIP_W     = $clog2(RECIP + 1);
   localparam int     PROD_W      = MAG_W + RECIP_W;
   localparam int     NUM_W       = MAG_W + RATE_W;
   localparam int     REM_W       = MAG_W + 1;

   localparam int REQ_DATA_W = STEP_FIELDS * STEP_W;
   localparam int RSP_BITS   = 3 * MASK_W + 1;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - RSP_BITS;

   localparam int RSP_Q_DEPTH = 4;
   localparam int RSP_Q_AW    = $clog2(RSP_Q_DEPTH);

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   typedef logic [AXIS_W-1:0]       axis_idx_type;
   typedef logic [MAG_W-1:0]        mag_type;
   typedef logic [ACC_W-1:0]        acc_type;
   typedef logic [RATE_W-1:0]       rate_type;
   typedef logic [SUM_W-1:0]        sum_type;
   typedef logic [PROD_W-1:0]       prod_type;
   typedef logic [NUM_W-1:0]        num_type;
   typedef logic [REM_W-1:0]        rem_type;
   typedef logic [STEP_W-1:0]       step_type;
   typedef logic [STEP_W:0]         absval_type;
   typedef logic [MASK_W-1:0]       mask_type;
   typedef logic [RSP_Q_AW-1:0]     qptr_type;
   typedef logic [RSP_Q_AW:0]       qcnt_type;
   typedef logic [RSP_Q_AW+1:0]     qsum_type;

   // One axis operation walking down the pipeline.
   typedef struct packed {
      logic         valid;
      logic         tick;
      logic         last;
      axis_idx_type axis;
      logic         neg;
      mag_type      mag;
      rate_type     quot;
   } op_type;

   // Per-axis state word held in the axis memory.
   typedef struct packed {
      acc_type  accum;
      rate_type rate;
      mag_type  target;
      mag_type  done;
      logic     pending;
      logic     reverse;
   } axis_word_type;

   // Outcome of one axis operation.
   typedef struct packed {
      logic         valid;
      logic         tick;
      logic         last;
      axis_idx_type axis;
      logic         start;
      logic         stop;
      logic         dir;
   } ev_type;

   typedef struct packed {
      logic     last;
      logic     active;
      mask_type dir_mask;
      mask_type end_mask;
      mask_type start_mask;
   } rsp_type;

   typedef struct packed {
      logic credit_ok;
      logic full;
   } stat_type;

endpackage

`default_nettype wire

// ===== sv/multi_axis_dda_step_generator_unit.sv =====
// ----------------------------------------------------------------------------
// Multi-axis DDA step generator
// Six-axis digital differential analyzer producing step pulse start, end and
// direction masks per tick beat.
// ----------------------------------------------------------------------------
// A beat with tuser 0 loads a segment of six signed step counts; a beat with
// tuser 1 is one tick and returns one result beat. Every beat walks the axes
// through a single read-modify-write port of the axis state memory, one axis
// per cycle, so a new beat is accepted only once the walk has reached the last
// axis of the previous beat. Results wait in a four-entry queue; besides the
// axis walk, the input stalls only when queued and in-flight tick results fill
// it. After reset no clearing pass is needed: every axis reads as zero until
// first written.
`default_nettype none

module multi_axis_dda_step_generator_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // req_type
   input  wire logic                                req_tuser,
   // axis0_steps .. axis5_steps, 16 bits each, axis 0 lowest
   input  wire logic [mads_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // pulse_start_mask, pulse_end_mask, direction_mask, segment_active, zero fill
   output logic [mads_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   // segment_last
   output logic                                     rsp_tlast
);

   mads_pkg::op_type   op;
   mads_pkg::ev_type   ev;
   mads_pkg::rsp_type  rsp;
   mads_pkg::stat_type stat;
   logic               tick_accept;

   assign tick_accept = req_tvalid && req_tready && (req_tuser == mads_pkg::REQ_TICK);

   mads_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_kind  (req_tuser),
      .req_steps (req_tdata),
      .credit_ok (stat.credit_ok),
      .req_ready (req_tready),
      .op_out    (op)
   );

   mads_axis u_axis (
      .clock  (clock),
      .reset  (reset),
      .op_in  (op),
      .ev_out (ev)
   );

   mads_rsp u_rsp (
      .clock       (clock),
      .reset       (reset),
      .ev_in       (ev),
      .tick_accept (tick_accept),
      .rsp_ready   (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .rsp_out     (rsp),
      .stat_out    (stat)
   );

   assign rsp_tdata = {{mads_pkg::RSP_PAD_W{1'b0}}, rsp.active, rsp.dir_mask,
                       rsp.end_mask, rsp.start_mask};
   assign rsp_tlast = rsp.last;

   // The axes of one beat leave the memory stage in consecutive cycles.
   assert property (@(posedge clock) disable iff (reset)
      (ev.valid && !ev.last) |=>
         (ev.valid && (ev.axis == mads_pkg::axis_idx_type'($past(ev.axis) + 1'b1))))
      else $error("axis walk broken between memory stage cycles");

   // A finished tick never finds the result queue full.
   assert property (@(posedge clock) disable iff (reset)
      (ev.valid && ev.tick && ev.last) |-> !stat.full)
      else $error("tick result arrived with the result queue full");

   // The last tick of a segment is always an active tick.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> rsp_tdata[3*mads_pkg::MASK_W])
      else $error("segment_last without segment_active");

endmodule

`default_nettype wire

// ===== sv/mads_seq.sv =====
// ----------------------------------------------------------------------------
// Step generator axis sequencer
// Holds the accepted beat, walks its axes one per cycle and computes the
// magnitude and the reciprocal rate estimate for each axis.
// ----------------------------------------------------------------------------
`default_nettype none

module mads_seq (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   input  wire logic                                 req_kind,
   input  wire logic [mads_pkg::REQ_DATA_W-1:0]      req_steps,
   input  wire logic                                 credit_ok,
   output logic                                      req_ready,
   output mads_pkg::op_type                          op_out
);

   logic                        busy_ff, busy_in;
   logic                        kind_ff, kind_in;
   mads_pkg::axis_idx_type      axis_ff, axis_in;
   mads_pkg::step_type          steps_ff [mads_pkg::AXIS_COUNT];
   mads_pkg::step_type          steps_in [mads_pkg::AXIS_COUNT];
   mads_pkg::op_type            s1_ff, s1_in;
   mads_pkg::op_type            s2_ff, s2_in;
   logic                        at_last;
   logic                        accept;
   logic                        neg;
   mads_pkg::absval_type        ext;
   mads_pkg::absval_type        absv;
   mads_pkg::prod_type          prod;

   assign at_last   = (axis_ff == mads_pkg::axis_idx_type'(mads_pkg::AXIS_COUNT - 1));
   assign req_ready = (!busy_ff || at_last) && credit_ok;
   assign accept    = req_valid && req_ready;

   // Magnitude of the axis at the head of the shift line, saturated.
   always_comb begin
      neg  = steps_ff[0][mads_pkg::STEP_W-1];
      ext  = {steps_ff[0][mads_pkg::STEP_W-1], steps_ff[0]};
      absv = neg ? (mads_pkg::absval_type'(0) - ext) : ext;
      s1_in.valid = busy_ff;
      s1_in.tick  = (kind_ff == mads_pkg::REQ_TICK);
      s1_in.last  = at_last;
      s1_in.axis  = axis_ff;
      s1_in.neg   = neg;
      s1_in.mag   = (absv > mads_pkg::absval_type'(mads_pkg::SEGMENT_TICKS)) ?
                    mads_pkg::mag_type'(mads_pkg::SEGMENT_TICKS) :
                    mads_pkg::mag_type'(absv);
      s1_in.quot  = '0;
   end

   always_comb begin
      prod  = mads_pkg::prod_type'(s1_ff.mag) * mads_pkg::prod_type'(mads_pkg::RECIP);
      s2_in = s1_ff;
      s2_in.quot = mads_pkg::rate_type'(prod >> mads_pkg::RECIP_SHIFT);
   end

   always_comb begin
      busy_in = busy_ff;
      kind_in = kind_ff;
      axis_in = axis_ff;
      for (int i = 0; i < mads_pkg::AXIS_COUNT; i++) begin
         steps_in[i] = steps_ff[i];
      end
      if (accept) begin
         busy_in = 1'b1;
         kind_in = req_kind;
         axis_in = '0;
         for (int i = 0; i < mads_pkg::AXIS_COUNT; i++) begin
            steps_in[i] = '0;
         end
         for (int i = 0; i < mads_pkg::LOAD_FIELDS; i++) begin
            steps_in[i] = req_steps[i*mads_pkg::STEP_W +: mads_pkg::STEP_W];
         end
      end else if (busy_ff) begin
         if (at_last) begin
            busy_in = 1'b0;
         end else begin
            axis_in = mads_pkg::axis_idx_type'(axis_ff + 1'b1);
            for (int i = 0; i < mads_pkg::AXIS_COUNT - 1; i++) begin
               steps_in[i] = steps_ff[i+1];
            end
            steps_in[mads_pkg::AXIS_COUNT-1] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         axis_ff       <= '0;
         s1_ff.valid   <= 1'b0;
         s2_ff.valid   <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         axis_ff       <= axis_in;
         s1_ff.valid   <= s1_in.valid;
         s2_ff.valid   <= s2_in.valid;
      end
      kind_ff  <= kind_in;
      steps_ff <= steps_in;
      s1_ff.tick <= s1_in.tick;
      s1_ff.last <= s1_in.last;
      s1_ff.axis <= s1_in.axis;
      s1_ff.neg  <= s1_in.neg;
      s1_ff.mag  <= s1_in.mag;
      s1_ff.quot <= s1_in.quot;
      s2_ff.tick <= s2_in.tick;
      s2_ff.last <= s2_in.last;
      s2_ff.axis <= s2_in.axis;
      s2_ff.neg  <= s2_in.neg;
      s2_ff.mag  <= s2_in.mag;
      s2_ff.quot <= s2_in.quot;
   end

   assign op_out = s2_ff;

endmodule

`default_nettype wire

// ===== sv/mads_axis.sv =====
// ----------------------------------------------------------------------------
// Step generator axis state memory
// Reads the state word of one axis per cycle, applies a load or a tick and
// writes it back, forwarding the word when the next read hits the same axis.
// ----------------------------------------------------------------------------
`default_nettype none

module mads_axis (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mads_pkg::op_type  op_in,
   output mads_pkg::ev_type       ev_out
);

   mads_pkg::axis_word_type mem [mads_pkg::AXIS_COUNT];
   logic [mads_pkg::AXIS_COUNT-1:0] valid_ff;

   mads_pkg::op_type        op_ff;
   mads_pkg::rem_type       rem_ff, rem_in;
   mads_pkg::axis_word_type rd_word_ff;
   logic                    rd_vld_ff;
   logic                    fwd_ff;
   mads_pkg::axis_word_type fwd_word_ff;

   mads_pkg::num_type       num;
   mads_pkg::num_type       den;
   mads_pkg::axis_word_type cur;
   mads_pkg::axis_word_type wr_word;
   mads_pkg::rate_type      rate_new;
   mads_pkg::sum_type       sum;
   logic                    wr_en;
   logic                    start;

   // Remainder of mag * PHASE_SCALE against the quotient estimate.
   always_comb begin
      num    = mads_pkg::num_type'(op_in.mag) * mads_pkg::num_type'(mads_pkg::PHASE_SCALE);
      den    = mads_pkg::num_type'(op_in.quot) * mads_pkg::num_type'(mads_pkg::SEGMENT_TICKS);
      rem_in = mads_pkg::rem_type'(num - den);
   end

   assign wr_en = op_ff.valid;

   always_comb begin
      cur   = fwd_ff ? fwd_word_ff : (rd_vld_ff ? rd_word_ff : '0);
      start = 1'b0;
      sum   = '0;
      // The remainder lies below twice the segment length: it settles both
      // the floor correction and the rounding up.
      if (rem_ff > mads_pkg::rem_type'(mads_pkg::SEGMENT_TICKS)) begin
         rate_new = mads_pkg::rate_type'(op_ff.quot + 2'd2);
      end else if (rem_ff != '0) begin
         rate_new = mads_pkg::rate_type'(op_ff.quot + 2'd1);
      end else begin
         rate_new = op_ff.quot;
      end
      wr_word = cur;
      if (op_ff.tick) begin
         wr_word.pending = 1'b0;
         if (cur.done < cur.target) begin
            sum = mads_pkg::sum_type'(cur.accum) + mads_pkg::sum_type'(cur.rate);
            if (sum >= mads_pkg::sum_type'(mads_pkg::PHASE_SCALE)) begin
               wr_word.accum   = mads_pkg::acc_type'(sum -
                                 mads_pkg::sum_type'(mads_pkg::PHASE_SCALE));
               wr_word.pending = 1'b1;
               wr_word.done    = mads_pkg::mag_type'(cur.done + 1'b1);
               start           = 1'b1;
            end else begin
               wr_word.accum = mads_pkg::acc_type'(sum);
            end
         end
      end else begin
         wr_word.target  = op_ff.mag;
         wr_word.done    = '0;
         wr_word.reverse = op_ff.neg;
         wr_word.rate    = rate_new;
      end
   end

   always_comb begin
      ev_out.valid = op_ff.valid;
      ev_out.tick  = op_ff.tick;
      ev_out.last  = op_ff.last;
      ev_out.axis  = op_ff.axis;
      ev_out.start = start;
      ev_out.stop  = op_ff.tick && cur.pending;
      ev_out.dir   = wr_word.reverse;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff.valid <= 1'b0;
         valid_ff    <= '0;
         fwd_ff      <= 1'b0;
      end else begin
         op_ff.valid <= op_in.valid;
         if (wr_en) begin
            valid_ff[op_ff.axis] <= 1'b1;
         end
         fwd_ff <= wr_en && (op_ff.axis == op_in.axis);
      end
      op_ff.tick  <= op_in.tick;
      op_ff.last  <= op_in.last;
      op_ff.axis  <= op_in.axis;
      op_ff.neg   <= op_in.neg;
      op_ff.mag   <= op_in.mag;
      op_ff.quot  <= op_in.quot;
      rem_ff      <= rem_in;
      rd_word_ff  <= mem[op_in.axis];
      rd_vld_ff   <= valid_ff[op_in.axis];
      fwd_word_ff <= wr_word;
      if (wr_en) begin
         mem[op_ff.axis] <= wr_word;
      end
   end

endmodule

`default_nettype wire

// ===== sv/mads_rsp.sv =====
// ----------------------------------------------------------------------------
// Step generator result assembly
// Gathers the per-axis outcomes of a tick into masks, keeps the segment tick
// counter and queues finished results for the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module mads_rsp (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mads_pkg::ev_type  ev_in,
   input  wire logic              tick_accept,
   input  wire logic              rsp_ready,
   output logic                   rsp_valid,
   output mads_pkg::rsp_type      rsp_out,
   output mads_pkg::stat_type     stat_out
);

   mads_pkg::mask_type start_acc_ff, start_acc_in;
   mads_pkg::mask_type stop_acc_ff, stop_acc_in;
   mads_pkg::mask_type dir_acc_ff, dir_acc_in;
   mads_pkg::mag_type  ticks_ff, ticks_in;
   mads_pkg::rsp_type  q_ff [mads_pkg::RSP_Q_DEPTH];
   mads_pkg::qptr_type wr_ptr_ff, rd_ptr_ff;
   mads_pkg::qcnt_type count_ff, count_in;
   mads_pkg::qcnt_type inflight_ff, inflight_in;
   mads_pkg::mask_type start_cur, stop_cur, dir_cur;
   mads_pkg::rsp_type  result;
   logic               push;
   logic               pop;

   assign push = ev_in.valid && ev_in.tick && ev_in.last;
   assign pop  = (count_ff != '0) && rsp_ready;

   always_comb begin
      start_cur = start_acc_ff;
      stop_cur  = stop_acc_ff;
      dir_cur   = dir_acc_ff;
      for (int i = 0; i < mads_pkg::MASK_W; i++) begin
         if ((i < mads_pkg::AXIS_COUNT) &&
             (ev_in.axis == mads_pkg::axis_idx_type'(i))) begin
            start_cur[i] = start_acc_ff[i] | ev_in.start;
            stop_cur[i]  = stop_acc_ff[i] | ev_in.stop;
            dir_cur[i]   = dir_acc_ff[i] | ev_in.dir;
         end
      end
      result.start_mask = start_cur;
      result.end_mask   = stop_cur;
      result.dir_mask   = dir_cur;
      result.active     = (ticks_ff != '0);
      result.last       = (ticks_ff == mads_pkg::mag_type'(1));
   end

   always_comb begin
      start_acc_in = start_acc_ff;
      stop_acc_in  = stop_acc_ff;
      dir_acc_in   = dir_acc_ff;
      ticks_in     = ticks_ff;
      if (ev_in.valid && ev_in.tick) begin
         if (ev_in.last) begin
            start_acc_in = '0;
            stop_acc_in  = '0;
            dir_acc_in   = '0;
         end else begin
            start_acc_in = start_cur;
            stop_acc_in  = stop_cur;
            dir_acc_in   = dir_cur;
         end
      end
      if (ev_in.valid && ev_in.last) begin
         if (!ev_in.tick) begin
            ticks_in = mads_pkg::mag_type'(mads_pkg::SEGMENT_TICKS);
         end else if (ticks_ff != '0) begin
            ticks_in = mads_pkg::mag_type'(ticks_ff - 1'b1);
         end
      end
      count_in    = mads_pkg::qcnt_type'(count_ff + push - pop);
      inflight_in = mads_pkg::qcnt_type'(inflight_ff + tick_accept - push);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_acc_ff <= '0;
         stop_acc_ff  <= '0;
         dir_acc_ff   <= '0;
         ticks_ff     <= '0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         inflight_ff  <= '0;
      end else begin
         start_acc_ff <= start_acc_in;
         stop_acc_ff  <= stop_acc_in;
         dir_acc_ff   <= dir_acc_in;
         ticks_ff     <= ticks_in;
         count_ff     <= count_in;
         inflight_ff  <= inflight_in;
         if (push) begin
            wr_ptr_ff <= mads_pkg::qptr_type'(wr_ptr_ff + 1'b1);
         end
         if (pop) begin
            rd_ptr_ff <= mads_pkg::qptr_type'(rd_ptr_ff + 1'b1);
         end
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= result;
      end
   end

   assign rsp_valid = (count_ff != '0);
   assign rsp_out   = q_ff[rd_ptr_ff];

   // Room is reserved for every tick that is already in the pipeline.
   assign stat_out.credit_ok = (mads_pkg::qsum_type'(count_ff) + mads_pkg::qsum_type'(inflight_ff))
                               < mads_pkg::qsum_type'(mads_pkg::RSP_Q_DEPTH);
   assign stat_out.full      = (count_ff == mads_pkg::qcnt_type'(mads_pkg::RSP_Q_DEPTH));

endmodule

`default_nettype wire
